// File: sv/htfd_pkg.sv
// Shared types, constants and functions for the humidity/temperature frame decoder.
// Used by htfd_front, htfd_queue, htfd_back and the top level; depends on nothing.
package htfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Byte positions within the six-byte frame
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam logic [14:0] TEMP_SCALE = 15'd17500;
    localparam logic [13:0] HUM_SCALE  = 14'd12500;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
    localparam logic [14:0] HUM_OFFSET = 15'd600;
    localparam logic [14:0] HUM_MAX    = 15'd10000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_CRC = 2'd1,
        ST_HUM_CRC  = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
    } t_rec;

    // One byte of CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // floor(p / 65535) for p below 2^31: floor(p / 65536) plus one correction step
    function automatic logic [14:0] div65535(input logic [30:0] p);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = p[30:16];
        rem = {1'b0, p[15:0]} + {2'b00, q0};
        return q0 + ((rem >= 17'd65535) ? 15'd1 : 15'd0);
    endfunction

endpackage

// File: sv/htfd_front.sv
// Front end: accepts frame bytes, tracks position, runs the CRC and assembles both words.
// Pushes one record per completed frame; depends on htfd_pkg.
module htfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_frame_start,
    output logic              o_push,
    output htfd_pkg::t_rec    o_rec,
    input  logic              i_full
);

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic        r_tgood, n_tgood;

    logic        w_accept;
    logic [2:0]  w_pos;
    logic [7:0]  w_crc;
    logic [7:0]  w_crc_step;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_pos = i_frame_start ? htfd_pkg::POS_T_MSB : r_pos;
        w_crc = i_frame_start ? htfd_pkg::CRC_INIT : r_crc;
        // positions past the frame end restart the frame
        if (w_pos > htfd_pkg::POS_H_CRC) begin
            w_pos = htfd_pkg::POS_T_MSB;
            w_crc = htfd_pkg::CRC_INIT;
        end
    end

    assign w_crc_step = htfd_pkg::crc8_byte(w_crc, i_rx_byte);

    always_comb begin
        n_pos   = w_pos + 3'd1;
        n_crc   = w_crc_step;
        n_temp  = r_temp;
        n_hum   = r_hum;
        n_tgood = r_tgood;
        o_push  = 1'b0;
        o_rec.temp_word = r_temp;
        o_rec.hum_word  = r_hum;
        if (!r_tgood) begin
            o_rec.status = htfd_pkg::ST_TEMP_CRC;
        end else if (w_crc != i_rx_byte) begin
            o_rec.status = htfd_pkg::ST_HUM_CRC;
        end else begin
            o_rec.status = htfd_pkg::ST_OK;
        end
        unique case (w_pos)
            htfd_pkg::POS_T_MSB: n_temp = {i_rx_byte, 8'h00};
            htfd_pkg::POS_T_LSB: n_temp = {r_temp[15:8], i_rx_byte};
            htfd_pkg::POS_T_CRC: begin
                n_tgood = (w_crc == i_rx_byte);
                n_crc   = htfd_pkg::CRC_INIT;
            end
            htfd_pkg::POS_H_MSB: n_hum = {i_rx_byte, 8'h00};
            htfd_pkg::POS_H_LSB: n_hum = {r_hum[15:8], i_rx_byte};
            default: begin
                n_pos  = htfd_pkg::POS_T_MSB;
                n_crc  = htfd_pkg::CRC_INIT;
                o_push = w_accept;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= htfd_pkg::POS_T_MSB;
            r_crc   <= htfd_pkg::CRC_INIT;
            r_temp  <= 16'h0000;
            r_hum   <= 16'h0000;
            r_tgood <= 1'b0;
        end else if (w_accept) begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_temp  <= n_temp;
            r_hum   <= n_hum;
            r_tgood <= n_tgood;
        end
    end

endmodule

// File: sv/htfd_queue.sv
// Short record queue between the front end and the scaling back end.
// Depends on htfd_pkg for the record type.
module htfd_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  htfd_pkg::t_rec    i_rec,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output htfd_pkg::t_rec    o_rec
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    htfd_pkg::t_rec r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_do_pop;

    assign o_full   = (r_cnt == CW'(DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_rec    = r_mem[r_rd];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !w_do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && w_do_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: sv/htfd_back.sv
// Back end: scales raw words to hundredths in two stages and holds the result register.
// Depends on htfd_pkg for the record type and the divide-by-65535 helper.
module htfd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_pop,
    input  htfd_pkg::t_rec        i_rec,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic signed [14:0]    o_temperature_centi,
    output logic [13:0]           o_humidity_centi,
    output logic [15:0]           o_temperature_word,
    output logic [15:0]           o_humidity_word
);

    // stage 1: constant products
    logic                r_s1_valid;
    htfd_pkg::t_rec      r_s1_rec;
    logic [30:0]         r_s1_tprod;
    logic [29:0]         r_s1_hprod;

    // stage 2: output register
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic signed [14:0]  r_out_temp;
    logic [13:0]         r_out_hum;
    logic [15:0]         r_out_tword;
    logic [15:0]         r_out_hword;

    logic                w_en2, w_en1;
    logic [14:0]         w_tq, w_hq;
    logic signed [15:0]  w_t;
    logic [14:0]         w_h;

    assign w_en2 = !r_out_valid || i_ready;
    assign w_en1 = !r_s1_valid || w_en2;
    assign o_pop = i_valid && w_en1;

    assign w_tq = htfd_pkg::div65535(r_s1_tprod);
    assign w_hq = htfd_pkg::div65535({1'b0, r_s1_hprod});
    assign w_t  = $signed({1'b0, w_tq}) - htfd_pkg::TEMP_OFFSET;

    // clip humidity to 0..10000
    always_comb begin
        if (w_hq < htfd_pkg::HUM_OFFSET) begin
            w_h = '0;
        end else if (w_hq - htfd_pkg::HUM_OFFSET > htfd_pkg::HUM_MAX) begin
            w_h = htfd_pkg::HUM_MAX;
        end else begin
            w_h = w_hq - htfd_pkg::HUM_OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_s1_rec   <= i_rec;
            r_s1_tprod <= 31'(i_rec.temp_word * htfd_pkg::TEMP_SCALE);
            r_s1_hprod <= 30'(i_rec.hum_word * htfd_pkg::HUM_SCALE);
        end
        if (w_en2 && r_s1_valid) begin
            r_out_status <= r_s1_rec.status;
            r_out_temp   <= w_t[14:0];
            r_out_hum    <= w_h[13:0];
            r_out_tword  <= r_s1_rec.temp_word;
            r_out_hword  <= r_s1_rec.hum_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_valid <= i_valid;
            end
            if (w_en2) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_out_status;
    assign o_temperature_centi = r_out_temp;
    assign o_humidity_centi    = r_out_hum;
    assign o_temperature_word  = r_out_tword;
    assign o_humidity_word     = r_out_hword;

endmodule

// File: sv/humidity_temperature_frame_decoder.sv
// Humidity/temperature frame decoder: one byte accepted per cycle while the queue has room, one result per frame.
// After acceptance of the sixth byte the record enters the queue, then passes the product
// register and the output register; both hold while the output is not taken.
// Throughput one byte per cycle; input stalls only while the queue is full.
// Reset (synchronous, active low) empties the queue and pipeline and restarts the frame.
// Depends on htfd_pkg, htfd_front, htfd_queue and htfd_back.
module humidity_temperature_frame_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [14:0] o_temperature_centi,
    output logic [13:0]        o_humidity_centi,
    output logic [15:0]        o_temperature_word,
    output logic [15:0]        o_humidity_word
);

    logic           w_push, w_full, w_q_valid, w_pop;
    htfd_pkg::t_rec w_push_rec, w_pop_rec;

    htfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_push        (w_push),
        .o_rec         (w_push_rec),
        .i_full        (w_full)
    );

    htfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_rec   (w_pop_rec)
    );

    htfd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (w_q_valid),
        .o_pop               (w_pop),
        .i_rec               (w_pop_rec),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_status            (o_status),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_temperature_word  (o_temperature_word),
        .o_humidity_word     (o_humidity_word)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue written while full");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= htfd_pkg::ST_HUM_CRC))
        else $error("invalid status code");

    a_hum_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_humidity_centi <= 14'd10000))
        else $error("humidity out of range");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> !($past(w_q_valid) && !w_q_valid && w_full))
        else $error("queue state inconsistent after pop");
`endif

endmodule
